>>> rtl/srm_pkg.sv
`default_nettype none

package srm_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int VALUE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int SLOPE_BITS    = 48;
  localparam int WIN_BITS      = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_BEGIN   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_END     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STOP_LEVEL     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEEP_LAST_EDGE = 3'd4;

  localparam logic [SLOPE_BITS-1:0] SLOPE_POS_CAP = {1'b0, {(SLOPE_BITS-1){1'b1}}};
  localparam logic [SLOPE_BITS-1:0] SLOPE_NEG_CAP = {1'b1, {(SLOPE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    PH_WAITING,
    PH_BELOW,
    PH_BETWEEN,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_EVAL,
    SQ_LO_GO,
    SQ_LO_WAIT,
    SQ_HI_GO,
    SQ_HI_WAIT,
    SQ_COMMIT,
    SQ_SLOPE_GO,
    SQ_SLOPE_WAIT,
    SQ_OUT
  } seq_state_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/srm_if.sv
`default_nettype none

interface srm_in_if import srm_pkg::*; #(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [TIME_BITS-1:0]         sample_time;
  logic signed [VALUE_BITS-1:0] sample_value;
  logic                         end_of_wave;

  modport source(output valid, sample_time, sample_value, end_of_wave, input ready);
  modport sink(input valid, sample_time, sample_value, end_of_wave, output ready);
endinterface

interface srm_out_if import srm_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [SLOPE_BITS-1:0] slope;
  logic                         edge_found;

  modport source(output valid, slope, edge_found, input ready);
  modport sink(input valid, slope, edge_found, output ready);
endinterface

`default_nettype wire

>>> rtl/srm_muldiv.sv
`default_nettype none

module srm_muldiv #(
  parameter int A_BITS    = 56,
  parameter int D_BITS    = 48,
  parameter int STEP_BITS = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [A_BITS-1:0]    a_in,
  input  wire logic [D_BITS-1:0]    b_in,
  input  wire logic [D_BITS-1:0]    d_in,
  input  wire logic [STEP_BITS-1:0] steps,
  output logic                      done,
  output logic [A_BITS-1:0]         quot
);

  logic [A_BITS-1:0]    a_r, a_nxt;
  logic [D_BITS-1:0]    b_r, b_nxt;
  logic [D_BITS-1:0]    d_r, d_nxt;
  logic [D_BITS-1:0]    rem_r, rem_nxt;
  logic [A_BITS-1:0]    quot_r, quot_nxt;
  logic [STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;

  logic [D_BITS+1:0] sum;
  logic [D_BITS+1:0] d_one;
  logic [D_BITS+1:0] d_two;
  logic [D_BITS-1:0] rem_step;
  logic [1:0]        inc;

  always_comb begin
    d_one = {2'b00, d_r};
    d_two = {1'b0, d_r, 1'b0};
    sum   = {1'b0, rem_r, 1'b0} + (a_r[A_BITS-1] ? {2'b00, b_r} : '0);
    if (sum >= d_two) begin
      rem_step = D_BITS'(sum - d_two);
      inc      = 2'd2;
    end else if (sum >= d_one) begin
      rem_step = D_BITS'(sum - d_one);
      inc      = 2'd1;
    end else begin
      rem_step = D_BITS'(sum);
      inc      = 2'd0;
    end
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a_in;
      b_nxt    = b_in;
      d_nxt    = d_in;
      rem_nxt  = '0;
      quot_nxt = '0;
      cnt_nxt  = steps;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      a_nxt    = a_r << 1;
      rem_nxt  = rem_step;
      quot_nxt = (quot_r << 1) + A_BITS'(inc);
      cnt_nxt  = cnt_r - STEP_BITS'(1);
      if (cnt_r == STEP_BITS'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

>>> rtl/slew_rate_measure.sv
`default_nettype none

// Measures the rising-edge slew rate of a sampled waveform. Each input transfer carries one
// sample; samples whose time lies inside the window registers are tracked for a rise through
// start_level and then stop_level, with each crossing time found by linear interpolation
// against the previous in-window sample. The sample flagged end_of_wave is tracked first and
// then yields one result transfer: the slope in value units per tick with 16 fractional bits,
// saturated, and edge_found; the tracking state then clears. Registers sit on the APB port at
// byte addresses 0 (window_begin), 4 (window_end), 8 (start_level), 12 (stop_level) and 16
// (keep_last_edge). Work on a sample runs through one bit-serial multiply-divide unit that
// produces one quotient bit per cycle, and the block takes no new sample until it finishes.
// A sample that needs no crossing does not use the unit; each interpolated crossing adds one
// division (at most two per sample), and end_of_wave adds a further division for the slope.
module slew_rate_measure import srm_pkg::*; #(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  srm_in_if.sink                        in_chan,
  srm_out_if.source                     out_chan,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  localparam int CW = TIME_BITS + FRAC_BITS;
  localparam int NW = VALUE_BITS + 2 * FRAC_BITS;
  localparam int AW = max_int(CW, NW);
  localparam int DW = max_int(CW, VALUE_BITS);
  localparam int SW = $clog2(AW + 1);
  localparam int XW = max_int(AW, SLOPE_BITS);
  localparam int WW = max_int(TIME_BITS, WIN_BITS);
  localparam int VB = VALUE_BITS;

  logic [WIN_BITS-1:0]  win_begin_r;
  logic [WIN_BITS-1:0]  win_end_r;
  logic signed [VB-1:0] start_level_r;
  logic signed [VB-1:0] stop_level_r;
  logic                 keep_last_r;

  seq_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;

  logic [TIME_BITS-1:0] t_r, t_nxt;
  logic signed [VB-1:0] v_r, v_nxt;
  logic                 eow_r, eow_nxt;
  logic [TIME_BITS-1:0] prev_time_r, prev_time_nxt;
  logic signed [VB-1:0] prev_value_r, prev_value_nxt;
  logic [CW-1:0]        tent_r, tent_nxt;
  logic [CW-1:0]        start_r, start_nxt;
  logic [CW-1:0]        stop_r, stop_nxt;
  logic                 stop_seen_r, stop_seen_nxt;
  logic                 need_lo_r, need_lo_nxt;
  logic                 need_hi_r, need_hi_nxt;
  logic                 lo_to_start_r, lo_to_start_nxt;
  logic                 upd_r, upd_nxt;
  logic                 slope_neg_r, slope_neg_nxt;
  logic [SLOPE_BITS-1:0] res_slope_r, res_slope_nxt;
  logic                 res_found_r, res_found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SLOPE_BITS-1:0] out_slope_r, out_slope_nxt;
  logic                 out_found_r, out_found_nxt;

  logic                    cfg_wr;
  logic [CFG_IDX_BITS-1:0] cfg_idx;

  logic   in_win, lvl_ok, is_below, is_between, is_above;
  logic   upd_c, need_lo_c, need_hi_c, lo_start_c, copy_c, seen_c;
  phase_t phase_c;

  logic signed [VB-1:0] cross_level;
  logic signed [VB:0]   den, num;
  logic                 den_pos;
  logic [VB-1:0]        num_clip;
  logic [TIME_BITS-1:0] dt_step;
  logic [CW-1:0]        cross_a, cross_base, t_fix, cross_val;

  logic signed [VB:0]    lvl_diff;
  logic                  lvl_neg;
  logic [VB-1:0]         lvl_mag;
  logic                  cr_neg;
  logic [CW-1:0]         cr_mag;
  logic                  slope_run;
  logic [XW-1:0]         q_ext, cap_ext;
  logic [SLOPE_BITS-1:0] sat_mag, sat_slope;
  logic                  out_free;

  logic          div_start, div_done;
  logic [AW-1:0] div_a, div_quot;
  logic [DW-1:0] div_b, div_d;
  logic [SW-1:0] div_steps;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_begin_r   <= '0;
      win_end_r     <= '1;
      start_level_r <= '0;
      stop_level_r  <= '0;
      keep_last_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WINDOW_BEGIN:   win_begin_r   <= pwdata[WIN_BITS-1:0];
        REG_WINDOW_END:     win_end_r     <= pwdata[WIN_BITS-1:0];
        REG_START_LEVEL:    start_level_r <= pwdata[VB-1:0];
        REG_STOP_LEVEL:     stop_level_r  <= pwdata[VB-1:0];
        REG_KEEP_LAST_EDGE: keep_last_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WINDOW_BEGIN:   prdata = CFG_DATA_BITS'(win_begin_r);
      REG_WINDOW_END:     prdata = CFG_DATA_BITS'(win_end_r);
      REG_START_LEVEL:    prdata = CFG_DATA_BITS'(start_level_r);
      REG_STOP_LEVEL:     prdata = CFG_DATA_BITS'(stop_level_r);
      REG_KEEP_LAST_EDGE: prdata = CFG_DATA_BITS'(keep_last_r);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    in_win     = (WW'(t_r) >= WW'(win_begin_r)) && (WW'(t_r) <= WW'(win_end_r));
    lvl_ok     = start_level_r <= stop_level_r;
    is_below   = (v_r <= start_level_r) && lvl_ok;
    is_between = (start_level_r <= v_r) && (v_r <= stop_level_r);
    is_above   = lvl_ok && (stop_level_r <= v_r);
    upd_c      = in_win && (phase_r != PH_DONE);
    need_lo_c  = 1'b0;
    need_hi_c  = 1'b0;
    lo_start_c = 1'b0;
    copy_c     = 1'b0;
    seen_c     = 1'b0;
    phase_c    = phase_r;
    if (in_win) begin
      case (phase_r)
        PH_WAITING: begin
          if (is_below) begin
            phase_c = PH_BELOW;
          end
        end
        PH_BELOW: begin
          if (is_below) begin
            phase_c = PH_BELOW;
          end else if (is_between) begin
            phase_c   = PH_BETWEEN;
            need_lo_c = 1'b1;
          end else if (is_above) begin
            phase_c    = PH_DONE;
            need_lo_c  = 1'b1;
            lo_start_c = 1'b1;
            need_hi_c  = 1'b1;
            seen_c     = 1'b1;
          end
        end
        PH_BETWEEN: begin
          if (is_below) begin
            phase_c = PH_BELOW;
          end else if (is_between) begin
            phase_c = PH_BETWEEN;
          end else if (is_above) begin
            phase_c   = keep_last_r ? PH_WAITING : PH_DONE;
            copy_c    = 1'b1;
            need_hi_c = 1'b1;
            seen_c    = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cross_level = ((state_r == SQ_LO_GO) || (state_r == SQ_LO_WAIT)) ? start_level_r
                                                                    : stop_level_r;
    den     = (VB+1)'(v_r) - (VB+1)'(prev_value_r);
    num     = (VB+1)'(cross_level) - (VB+1)'(prev_value_r);
    den_pos = !den[VB] && (den != '0);
    if (num[VB]) begin
      num_clip = '0;
    end else if (num > den) begin
      num_clip = den[VB-1:0];
    end else begin
      num_clip = num[VB-1:0];
    end
    dt_step    = (t_r >= prev_time_r) ? (t_r - prev_time_r) : '0;
    cross_a    = CW'(dt_step) << FRAC_BITS;
    cross_base = CW'(prev_time_r) << FRAC_BITS;
    t_fix      = CW'(t_r) << FRAC_BITS;
    cross_val  = cross_base + CW'(div_quot);

    lvl_diff  = (VB+1)'(stop_level_r) - (VB+1)'(start_level_r);
    lvl_neg   = lvl_diff[VB];
    lvl_mag   = lvl_neg ? VB'(-lvl_diff) : VB'(lvl_diff);
    cr_neg    = stop_r < start_r;
    cr_mag    = cr_neg ? (start_r - stop_r) : (stop_r - start_r);
    slope_run = stop_seen_r && (lvl_mag != '0) && (cr_mag != '0);
    q_ext     = XW'(div_quot);
    cap_ext   = XW'(slope_neg_r ? SLOPE_NEG_CAP : SLOPE_POS_CAP);
    sat_mag   = (q_ext > cap_ext) ? SLOPE_BITS'(cap_ext) : SLOPE_BITS'(q_ext);
    sat_slope = slope_neg_r ? (~sat_mag + SLOPE_BITS'(1)) : sat_mag;
    out_free  = !out_valid_r || out_chan.ready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SQ_IDLE:       if (in_chan.valid) state_nxt = SQ_EVAL;
      SQ_EVAL: begin
        if (need_lo_c) begin
          state_nxt = SQ_LO_GO;
        end else if (need_hi_c) begin
          state_nxt = SQ_HI_GO;
        end else begin
          state_nxt = SQ_COMMIT;
        end
      end
      SQ_LO_GO: begin
        if (den_pos) begin
          state_nxt = SQ_LO_WAIT;
        end else begin
          state_nxt = need_hi_r ? SQ_HI_GO : SQ_COMMIT;
        end
      end
      SQ_LO_WAIT:    if (div_done) state_nxt = need_hi_r ? SQ_HI_GO : SQ_COMMIT;
      SQ_HI_GO:      state_nxt = den_pos ? SQ_HI_WAIT : SQ_COMMIT;
      SQ_HI_WAIT:    if (div_done) state_nxt = SQ_COMMIT;
      SQ_COMMIT:     state_nxt = eow_r ? SQ_SLOPE_GO : SQ_IDLE;
      SQ_SLOPE_GO:   state_nxt = slope_run ? SQ_SLOPE_WAIT : SQ_OUT;
      SQ_SLOPE_WAIT: if (div_done) state_nxt = SQ_OUT;
      SQ_OUT:        if (out_free) state_nxt = SQ_IDLE;
      default:       state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    div_start     = 1'b0;
    div_a         = AW'(cross_a) << (AW - CW);
    div_b         = DW'(num_clip);
    div_d         = DW'(den[VB-1:0]);
    div_steps     = SW'(CW);
    case (state_r)
      SQ_IDLE:     in_chan.ready = 1'b1;
      SQ_LO_GO:    div_start     = den_pos;
      SQ_HI_GO:    div_start     = den_pos;
      SQ_SLOPE_GO: begin
        div_start = slope_run;
        div_a     = AW'(lvl_mag) << (AW - VB);
        div_b     = DW'(1);
        div_d     = DW'(cr_mag);
        div_steps = SW'(NW);
      end
      default: ;
    endcase
  end

  always_comb begin
    t_nxt           = t_r;
    v_nxt           = v_r;
    eow_nxt         = eow_r;
    phase_nxt       = phase_r;
    prev_time_nxt   = prev_time_r;
    prev_value_nxt  = prev_value_r;
    tent_nxt        = tent_r;
    start_nxt       = start_r;
    stop_nxt        = stop_r;
    stop_seen_nxt   = stop_seen_r;
    need_lo_nxt     = need_lo_r;
    need_hi_nxt     = need_hi_r;
    lo_to_start_nxt = lo_to_start_r;
    upd_nxt         = upd_r;
    slope_neg_nxt   = slope_neg_r;
    res_slope_nxt   = res_slope_r;
    res_found_nxt   = res_found_r;
    case (state_r)
      SQ_IDLE: begin
        if (in_chan.valid) begin
          t_nxt   = in_chan.sample_time;
          v_nxt   = in_chan.sample_value;
          eow_nxt = in_chan.end_of_wave;
        end
      end
      SQ_EVAL: begin
        need_lo_nxt     = need_lo_c;
        need_hi_nxt     = need_hi_c;
        lo_to_start_nxt = lo_start_c;
        upd_nxt         = upd_c;
        phase_nxt       = phase_c;
        if (copy_c) start_nxt = tent_r;
        if (seen_c) stop_seen_nxt = 1'b1;
      end
      SQ_LO_GO: begin
        if (!den_pos) begin
          if (lo_to_start_r) begin
            start_nxt = t_fix;
          end else begin
            tent_nxt = t_fix;
          end
        end
      end
      SQ_LO_WAIT: begin
        if (div_done) begin
          if (lo_to_start_r) begin
            start_nxt = cross_val;
          end else begin
            tent_nxt = cross_val;
          end
        end
      end
      SQ_HI_GO:   if (!den_pos) stop_nxt = t_fix;
      SQ_HI_WAIT: if (div_done) stop_nxt = cross_val;
      SQ_COMMIT: begin
        if (upd_r) begin
          prev_time_nxt  = t_r;
          prev_value_nxt = v_r;
        end
      end
      SQ_SLOPE_GO: begin
        slope_neg_nxt = lvl_neg ^ cr_neg;
        res_found_nxt = stop_seen_r;
        if (!stop_seen_r || (lvl_mag == '0)) begin
          res_slope_nxt = '0;
        end else if (cr_mag == '0) begin
          res_slope_nxt = lvl_neg ? SLOPE_NEG_CAP : SLOPE_POS_CAP;
        end
      end
      SQ_SLOPE_WAIT: if (div_done) res_slope_nxt = sat_slope;
      SQ_OUT: begin
        if (out_free) begin
          phase_nxt     = PH_WAITING;
          stop_seen_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_slope_nxt = out_slope_r;
    out_found_nxt = out_found_r;
    if ((state_r == SQ_OUT) && out_free) begin
      out_valid_nxt = 1'b1;
      out_slope_nxt = res_slope_r;
      out_found_nxt = res_found_r;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= SQ_IDLE;
      phase_r       <= PH_WAITING;
      stop_seen_r   <= 1'b0;
      need_lo_r     <= 1'b0;
      need_hi_r     <= 1'b0;
      lo_to_start_r <= 1'b0;
      upd_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      stop_seen_r   <= stop_seen_nxt;
      need_lo_r     <= need_lo_nxt;
      need_hi_r     <= need_hi_nxt;
      lo_to_start_r <= lo_to_start_nxt;
      upd_r         <= upd_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r          <= t_nxt;
    v_r          <= v_nxt;
    eow_r        <= eow_nxt;
    prev_time_r  <= prev_time_nxt;
    prev_value_r <= prev_value_nxt;
    tent_r       <= tent_nxt;
    start_r      <= start_nxt;
    stop_r       <= stop_nxt;
    slope_neg_r  <= slope_neg_nxt;
    res_slope_r  <= res_slope_nxt;
    res_found_r  <= res_found_nxt;
    out_slope_r  <= out_slope_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.slope      = out_slope_r;
  assign out_chan.edge_found = out_found_r;

  srm_muldiv #(
    .A_BITS    (AW),
    .D_BITS    (DW),
    .STEP_BITS (SW)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a_in  (div_a),
    .b_in  (div_b),
    .d_in  (div_d),
    .steps (div_steps),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

`default_nettype wire
